>>> rtl/multi_slot_tick_timer_table_macros.svh
// assertion helpers for the timer table
`ifndef MULTI_SLOT_TICK_TIMER_TABLE_MACROS_SVH
`define MULTI_SLOT_TICK_TIMER_TABLE_MACROS_SVH

`ifndef SYNTHESIS

`define MSTT_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

`define MSTT_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`else

`define MSTT_ASSERT_NOW(lbl, clk, rst, ante, cons)

`define MSTT_ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

>>> rtl/mstt_pkg.sv
`timescale 1ns / 1ps

package mstt_pkg;

   localparam int NumTimers = 8;
   localparam int SlotW     = 3;
   localparam int CountW    = 16;
   localparam int CmdW      = 2;
   localparam int KindW     = 2;
   localparam int IdxW      = 8;

   localparam logic [CmdW-1:0] CmdStart  = 2'd0;
   localparam logic [CmdW-1:0] CmdDelete = 2'd1;
   localparam logic [CmdW-1:0] CmdTick   = 2'd2;

   localparam logic [KindW-1:0] KindStart   = 2'd0;
   localparam logic [KindW-1:0] KindDelete  = 2'd1;
   localparam logic [KindW-1:0] KindExpiry  = 2'd2;
   localparam logic [KindW-1:0] KindNoExpiry = 2'd3;

   localparam logic StIdle = 1'b0;
   localparam logic StScan = 1'b1;

   typedef struct packed {
      logic start;
      logic del;
      logic tick;
      logic shift;
      logic flush;
   } mstt_ctrl_type;

endpackage

>>> rtl/mstt_cell.sv
`timescale 1ns / 1ps

module mstt_cell (
   input  logic                        clock,
   input  logic                        reset,
   input  mstt_pkg::mstt_ctrl_type     ctrl,
   input  logic                        del_sel,
   input  logic [mstt_pkg::CountW-1:0] init_count,
   input  logic [mstt_pkg::CountW-1:0] reload_value,
   input  logic                        grab_in,
   output logic                        grab_out,
   output logic                        take,
   input  logic                        token_in,
   output logic                        token_out,
   input  logic                        pend_in,
   output logic                        pend_out,
   output logic                        fire_next,
   output logic                        hit,
   output logic                        is_last
);

   logic                        active_ff, active_in;
   logic [mstt_pkg::CountW-1:0] count_ff, count_in;
   logic [mstt_pkg::CountW-1:0] reload_ff, reload_in;
   logic                        fire_ff, fire_in;
   logic                        token_ff, token_in_nxt;
   logic [mstt_pkg::CountW-1:0] dec;

   // lowest free slot wins: grab ripples upward once a free cell is seen
   assign take     = !grab_in && !active_ff;
   assign grab_out = grab_in || !active_ff;

   assign dec       = (count_ff != '0) ? count_ff - 1'b1 : '0;
   assign fire_next = active_ff && (dec == '0);

   assign token_out = token_ff;
   assign pend_out  = fire_ff || pend_in;
   assign hit       = token_ff && fire_ff;
   assign is_last   = !pend_in;

   always_comb begin
      active_in = active_ff;
      count_in  = count_ff;
      reload_in = reload_ff;
      fire_in   = fire_ff;
      if (ctrl.start && take) begin
         active_in = 1'b1;
         count_in  = init_count;
         reload_in = reload_value;
      end
      if (ctrl.del && del_sel) begin
         active_in = 1'b0;
         count_in  = '0;
         reload_in = '0;
      end
      if (ctrl.tick) begin
         fire_in = fire_next;
         if (active_ff) begin
            if (dec != '0) begin
               count_in = dec;
            end else if (reload_ff != '0) begin
               count_in = reload_ff;
            end else begin
               active_in = 1'b0;
               count_in  = '0;
            end
         end
      end
      token_in_nxt = token_ff;
      if (ctrl.shift) begin
         token_in_nxt = token_in && !ctrl.flush;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         token_ff  <= 1'b0;
         fire_ff   <= 1'b0;
      end else begin
         active_ff <= active_in;
         token_ff  <= token_in_nxt;
         fire_ff   <= fire_in;
      end
      count_ff  <= count_in;
      reload_ff <= reload_in;
   end

endmodule

>>> rtl/multi_slot_tick_timer_table.sv
`timescale 1ns / 1ps
// start and delete: rsp word loads at the accept edge, next req taken as the rsp is taken
// tick: slots update on the accept edge, then a token walks the cell chain one slot per
// cycle, held at a firing slot until the rsp register frees up; each firing slot gives
// one expiry word and the last of them ends the scan; with no expiry the word loads on accept
// reset: all slots free, no word pending, rsp_valid low

`include "multi_slot_tick_timer_table_macros.svh"

module multi_slot_tick_timer_table (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [mstt_pkg::CmdW-1:0]         req_cmd,
   input  logic [mstt_pkg::CountW-1:0]       req_initial_count,
   input  logic [mstt_pkg::CountW-1:0]       req_reload_value,
   input  logic [mstt_pkg::IdxW-1:0]         req_slot_index,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [mstt_pkg::KindW-1:0]        rsp_kind,
   output logic [mstt_pkg::SlotW-1:0]        rsp_slot,
   output logic                              rsp_ok,
   output logic                              rsp_last
);

   localparam logic [mstt_pkg::IdxW-1:0] NumTimersIdx = mstt_pkg::IdxW'(mstt_pkg::NumTimers);

   logic state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [mstt_pkg::KindW-1:0] rsp_kind_ff, rsp_kind_in;
   logic [mstt_pkg::SlotW-1:0] rsp_slot_ff, rsp_slot_in;
   logic rsp_ok_ff, rsp_ok_in;
   logic rsp_last_ff, rsp_last_in;

   mstt_pkg::mstt_ctrl_type ctrl;
   logic [mstt_pkg::NumTimers:0]   grab;
   logic [mstt_pkg::NumTimers:0]   tok;
   logic [mstt_pkg::NumTimers:0]   pend;
   logic [mstt_pkg::NumTimers-1:0] take, fire_next, hit, is_last, del_sel;

   logic req_fire, is_start, is_del, is_tick, out_free;
   logic any_take, any_fire, hit_any, hit_last, in_range, load;
   logic [mstt_pkg::SlotW-1:0] take_slot, hit_slot;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == mstt_pkg::StIdle) && out_free;
   assign req_fire  = req_valid && req_ready;
   assign is_start  = req_fire && (req_cmd == mstt_pkg::CmdStart);
   assign is_del    = req_fire && (req_cmd == mstt_pkg::CmdDelete);
   assign is_tick   = req_fire && (req_cmd == mstt_pkg::CmdTick);
   assign in_range  = req_slot_index < NumTimersIdx;

   assign grab[0]                   = 1'b0;
   assign pend[mstt_pkg::NumTimers] = 1'b0;
   assign tok[0]                    = is_tick && any_fire;

   always_comb begin
      any_take  = |take;
      any_fire  = |fire_next;
      hit_any   = |hit;
      hit_last  = |(hit & is_last);
      take_slot = '0;
      hit_slot  = '0;
      for (int i = 0; i < mstt_pkg::NumTimers; i++) begin
         del_sel[i] = in_range && (req_slot_index[mstt_pkg::SlotW-1:0] == mstt_pkg::SlotW'(i));
         if (take[i]) take_slot = take_slot | mstt_pkg::SlotW'(i);
         if (hit[i])  hit_slot  = hit_slot  | mstt_pkg::SlotW'(i);
      end
   end

   always_comb begin
      ctrl.start = is_start;
      ctrl.del   = is_del && in_range;
      ctrl.tick  = is_tick;
      ctrl.flush = 1'b0;
      ctrl.shift = is_tick;
      state_in   = state_ff;
      load       = 1'b0;
      rsp_kind_in = rsp_kind_ff;
      rsp_slot_in = rsp_slot_ff;
      rsp_ok_in   = rsp_ok_ff;
      rsp_last_in = rsp_last_ff;
      unique case (state_ff)
         mstt_pkg::StIdle: begin
            if (is_start) begin
               load        = 1'b1;
               rsp_kind_in = mstt_pkg::KindStart;
               rsp_slot_in = any_take ? take_slot : '0;
               rsp_ok_in   = any_take;
               rsp_last_in = 1'b1;
            end else if (is_del) begin
               load        = 1'b1;
               rsp_kind_in = mstt_pkg::KindDelete;
               rsp_slot_in = in_range ? req_slot_index[mstt_pkg::SlotW-1:0] : '0;
               rsp_ok_in   = in_range;
               rsp_last_in = 1'b1;
            end else if (is_tick) begin
               if (any_fire) begin
                  state_in = mstt_pkg::StScan;
               end else begin
                  load        = 1'b1;
                  rsp_kind_in = mstt_pkg::KindNoExpiry;
                  rsp_slot_in = '0;
                  rsp_ok_in   = 1'b1;
                  rsp_last_in = 1'b1;
               end
            end
         end
         mstt_pkg::StScan: begin
            // token stalls on a firing slot until the output register frees up
            ctrl.shift = !hit_any || out_free;
            if (hit_any && out_free) begin
               load        = 1'b1;
               rsp_kind_in = mstt_pkg::KindExpiry;
               rsp_slot_in = hit_slot;
               rsp_ok_in   = 1'b1;
               rsp_last_in = hit_last;
               if (hit_last) begin
                  ctrl.flush = 1'b1;
                  state_in   = mstt_pkg::StIdle;
               end
            end
         end
         default: state_in = mstt_pkg::StIdle;
      endcase
      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   for (genvar g = 0; g < mstt_pkg::NumTimers; g++) begin : g_cell
      mstt_cell u_cell (
         .clock        (clock),
         .reset        (reset),
         .ctrl         (ctrl),
         .del_sel      (del_sel[g]),
         .init_count   (req_initial_count),
         .reload_value (req_reload_value),
         .grab_in      (grab[g]),
         .grab_out     (grab[g+1]),
         .take         (take[g]),
         .token_in     (tok[g]),
         .token_out    (tok[g+1]),
         .pend_in      (pend[g+1]),
         .pend_out     (pend[g]),
         .fire_next    (fire_next[g]),
         .hit          (hit[g]),
         .is_last      (is_last[g])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mstt_pkg::StIdle;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_kind_ff <= rsp_kind_in;
      rsp_slot_ff <= rsp_slot_in;
      rsp_ok_ff   <= rsp_ok_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_kind  = rsp_kind_ff;
   assign rsp_slot  = rsp_slot_ff;
   assign rsp_ok    = rsp_ok_ff;
   assign rsp_last  = rsp_last_ff;

   `MSTT_ASSERT_NOW(a_token_onehot, clock, reset, 1'b1, $onehot0(tok[mstt_pkg::NumTimers:1]))
   `MSTT_ASSERT_NOW(a_scan_has_token, clock, reset, state_ff == mstt_pkg::StScan, |tok[mstt_pkg::NumTimers:1])
   `MSTT_ASSERT_NOW(a_idle_no_token, clock, reset, state_ff == mstt_pkg::StIdle, !(|tok[mstt_pkg::NumTimers:1]))
   `MSTT_ASSERT_NEXT(a_hit_waits, clock, reset, hit_any && !out_free, hit_any && $stable(hit_slot))

endmodule
